// File: hdl/pump_cycler_and_heater_thermostat_core_macros.svh
// Assertion macros for the pump cycler and heater thermostat block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef PUMP_CYCLER_AND_HEATER_THERMOSTAT_CORE_MACROS_SVH
`define PUMP_CYCLER_AND_HEATER_THERMOSTAT_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define PHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pht assertion failed");

`define PHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pht assertion failed");

`else

`define PHT_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define PHT_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: hdl/pht_pkg.sv
// Shared types and constants for the pump cycler and heater thermostat.
// No dependencies.
package pht_pkg;

    localparam int unsigned TICKS_W = 12;
    localparam int unsigned COUNT_W = 13;
    localparam int unsigned TEMP_W  = 16;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned IDX_W   = 3;

    localparam logic [TICKS_W-1:0] ALWAYS_ON_LIMIT = TICKS_W'(90 * 40);

    localparam logic [IDX_W-1:0] REG_PUMP_ON  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PUMP_OFF = 3'd1;
    localparam logic [IDX_W-1:0] REG_HEAT_EN  = 3'd2;
    localparam logic [IDX_W-1:0] REG_SET_TEMP = 3'd3;
    localparam logic [IDX_W-1:0] REG_HYST     = 3'd4;

    typedef struct packed {
        logic [TICKS_W-1:0] pump_on_ticks;
        logic [TICKS_W-1:0] pump_off_ticks;
        logic               heat_enable;
        logic [TEMP_W-1:0]  set_temperature;
        logic [TEMP_W-1:0]  hysteresis;
    } cfg_t;

    typedef struct packed {
        logic pump_drive;
        logic heater_drive;
        logic next_edge_rising;
    } result_t;

endpackage

// File: hdl/pht_regs.sv
// APB-style configuration register file.
// Depends on pht_pkg.
module pht_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pht_pkg::ADDR_W-1:0]  paddr,
    input  logic [pht_pkg::DATA_W-1:0]  pwdata,
    output logic [pht_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output pht_pkg::cfg_t               cfg
);

    pht_pkg::cfg_t                 cfg_reg;
    logic [pht_pkg::IDX_W-1:0]     reg_idx;
    logic                          wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[pht_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                pht_pkg::REG_PUMP_ON: begin
                    cfg_reg.pump_on_ticks <= pwdata[pht_pkg::TICKS_W-1:0];
                end
                pht_pkg::REG_PUMP_OFF: begin
                    cfg_reg.pump_off_ticks <= pwdata[pht_pkg::TICKS_W-1:0];
                end
                pht_pkg::REG_HEAT_EN: begin
                    cfg_reg.heat_enable <= pwdata[0];
                end
                pht_pkg::REG_SET_TEMP: begin
                    cfg_reg.set_temperature <= pwdata[pht_pkg::TEMP_W-1:0];
                end
                pht_pkg::REG_HYST: begin
                    cfg_reg.hysteresis <= pwdata[pht_pkg::TEMP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            pht_pkg::REG_PUMP_ON:
                prdata = pht_pkg::DATA_W'(cfg_reg.pump_on_ticks);
            pht_pkg::REG_PUMP_OFF:
                prdata = pht_pkg::DATA_W'(cfg_reg.pump_off_ticks);
            pht_pkg::REG_HEAT_EN:
                prdata = pht_pkg::DATA_W'(cfg_reg.heat_enable);
            pht_pkg::REG_SET_TEMP:
                prdata = pht_pkg::DATA_W'(cfg_reg.set_temperature);
            pht_pkg::REG_HYST:
                prdata = pht_pkg::DATA_W'(cfg_reg.hysteresis);
            default:
                prdata = '0;
        endcase
    end

endmodule

// File: hdl/pht_step.sv
// Per-tick pump cycler and thermostat state with its next-state logic.
// Depends on pht_pkg and the assertion macro header.
`include "pump_cycler_and_heater_thermostat_core_macros.svh"

module pht_step (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step_en,
    input  logic [pht_pkg::TEMP_W-1:0]  temperature,
    input  pht_pkg::cfg_t               cfg,
    output pht_pkg::result_t            res_next
);

    logic [pht_pkg::COUNT_W-1:0]  count_reg;
    logic [pht_pkg::COUNT_W-1:0]  count_next;
    logic                         pump_reg;
    logic                         pump_next;
    logic                         heater_reg;
    logic                         heater_next;
    logic                         edge_reg;
    logic                         edge_next;

    logic                         force_off;
    logic                         force_on;
    logic [pht_pkg::COUNT_W-1:0]  on_ext;
    logic [pht_pkg::COUNT_W-1:0]  period_end;
    logic                         restart;
    logic [pht_pkg::TEMP_W:0]     temp_plus_hyst;
    logic [pht_pkg::TEMP_W:0]     set_plus_hyst;
    logic                         below_band;
    logic                         above_band;

    assign force_off  = (cfg.pump_on_ticks == '0);
    assign force_on   = (cfg.pump_on_ticks > pht_pkg::ALWAYS_ON_LIMIT);
    assign on_ext     = pht_pkg::COUNT_W'(cfg.pump_on_ticks);
    assign period_end = on_ext + pht_pkg::COUNT_W'(cfg.pump_off_ticks);
    assign restart    = (count_reg != '0) && (count_reg != on_ext) && (count_reg > period_end);

    always_comb begin
        pump_next  = pump_reg;
        count_next = count_reg;
        if (force_off) begin
            pump_next = 1'b0;
        end else if (force_on) begin
            pump_next = 1'b1;
        end else begin
            if (count_reg == '0) begin
                pump_next = 1'b1;
            end else if (count_reg == on_ext) begin
                pump_next = 1'b0;
            end
            count_next = restart ? '0 : count_reg + 1'b1;
        end
    end

    // temp < set - hyst  <=>  temp + hyst < set, kept unsigned
    assign temp_plus_hyst = {1'b0, temperature} + {1'b0, cfg.hysteresis};
    assign set_plus_hyst  = {1'b0, cfg.set_temperature} + {1'b0, cfg.hysteresis};
    assign below_band     = (temp_plus_hyst < {1'b0, cfg.set_temperature});
    assign above_band     = ({1'b0, temperature} > set_plus_hyst);

    always_comb begin
        heater_next = heater_reg;
        if (!cfg.heat_enable) begin
            heater_next = 1'b0;
        end else if (below_band) begin
            heater_next = 1'b1;
        end else if (above_band) begin
            heater_next = 1'b0;
        end
    end

    assign edge_next = ~edge_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            pump_reg   <= 1'b0;
            heater_reg <= 1'b0;
            edge_reg   <= 1'b0;
        end else if (step_en) begin
            count_reg  <= count_next;
            pump_reg   <= pump_next;
            heater_reg <= heater_next;
            edge_reg   <= edge_next;
        end
    end

    assign res_next.pump_drive       = pump_next;
    assign res_next.heater_drive     = heater_next;
    assign res_next.next_edge_rising = edge_next;

    `PHT_ASSERT_NXT(a_edge_toggles, aclk, aresetn, step_en, edge_reg != $past(edge_reg))
    `PHT_ASSERT_NXT(a_idle_holds, aclk, aresetn, !step_en,
        $stable(count_reg) && $stable(pump_reg) && $stable(heater_reg) && $stable(edge_reg))
    `PHT_ASSERT_NXT(a_heat_disabled, aclk, aresetn, step_en && !cfg.heat_enable, !heater_reg)
    `PHT_ASSERT_NXT(a_forced_count_held, aclk, aresetn, step_en && (force_off || force_on),
        count_reg == $past(count_reg))

endmodule

// File: hdl/pump_cycler_and_heater_thermostat_core.sv
// Pump cycler and heater thermostat, top level: input stage, result stage, glue.
// Depends on pht_pkg, pht_regs, pht_step and the assertion macro header.
//
// Usage:
//   Send one beat on the s_ channel per mains zero-cross tick, carrying the
//   measured temperature. Each beat yields exactly one result beat on the m_
//   channel: pump drive, heater drive and the edge to watch for next.
//   The beat is held in an input register, the state update runs in one
//   combinational pass, and the result lands in an output register.
//   The input register feeds the result register, which drives m_valid;
//   throughput is one beat per cycle while the receiver keeps m_ready high.
//   When the receiver stalls, the result register holds and one more beat
//   waits in the input register; s_ready then drops until m_ready returns.
//   Reset (aresetn low, synchronous) clears all configuration registers, the
//   cycle counter, the pump, heater and edge latches, and both stages.
//   Configure through the APB-style port while no beats are in flight:
//   register 0 pump on ticks, 1 pump off ticks, 2 heat enable,
//   3 set temperature, 4 hysteresis, at byte addresses 4*i.
`include "pump_cycler_and_heater_thermostat_core_macros.svh"

module pump_cycler_and_heater_thermostat_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pht_pkg::ADDR_W-1:0]  paddr,
    input  logic [pht_pkg::DATA_W-1:0]  pwdata,
    output logic [pht_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pht_pkg::TEMP_W-1:0]  s_temperature,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_pump_drive,
    output logic                        m_heater_drive,
    output logic                        m_next_edge_rising
);

    pht_pkg::cfg_t                 cfg;
    pht_pkg::result_t              res_next;
    pht_pkg::result_t              out_reg;
    logic                          in_valid_reg;
    logic [pht_pkg::TEMP_W-1:0]    temp_reg;
    logic                          out_valid_reg;
    logic                          advance;

    pht_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pht_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .temperature (temp_reg),
        .cfg         (cfg),
        .res_next    (res_next)
    );

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            temp_reg <= s_temperature;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_pump_drive       = out_reg.pump_drive;
    assign m_heater_drive     = out_reg.heater_drive;
    assign m_next_edge_rising = out_reg.next_edge_rising;

    `PHT_ASSERT_NXT(a_advance_fills_out, aclk, aresetn, advance, out_valid_reg)
    `PHT_ASSERT_NXT(a_stall_keeps_input, aclk, aresetn,
        in_valid_reg && out_valid_reg && !m_ready, in_valid_reg && $stable(temp_reg))
    `PHT_ASSERT_IMP(a_ready_when_empty, aclk, aresetn, !in_valid_reg, s_ready)

endmodule

// File: tb/sv/tb_pump_cycler_and_heater_thermostat_core.sv
`timescale 1ns / 100ps
// Self-checking bench for pump_cycler_and_heater_thermostat_core: ticks go in on the s_ channel,
// results are checked against an in-bench thermostat/pump model. Needs pht_pkg and the core RTL.
module tb_pump_cycler_and_heater_thermostat_core;

    logic                         aclk;
    logic                         aresetn = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [pht_pkg::ADDR_W-1:0]   paddr = '0;
    logic [pht_pkg::DATA_W-1:0]   pwdata = '0;
    logic [pht_pkg::DATA_W-1:0]   prdata;
    logic                         pready;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [pht_pkg::TEMP_W-1:0]   s_temperature = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic                         m_pump_drive;
    logic                         m_heater_drive;
    logic                         m_next_edge_rising;

    // thermostat/pump model state and register mirror
    pht_pkg::cfg_t                cfg_mirror = '0;
    logic [pht_pkg::COUNT_W-1:0]  tick_count = '0;
    logic                         pump_on = 1'b0;
    logic                         heater_on = 1'b0;
    logic                         edge_rising = 1'b0;

    logic [pht_pkg::TEMP_W-1:0]   pending_temps[$];
    pht_pkg::result_t             expected_drives[$];
    logic                         s_taken = 1'b0;
    int                           send_idle_pct = 29;
    int                           recv_idle_pct = 62;
    int                           errors = 0;
    int                           ticks_sent = 0;
    int                           beats_checked = 0;
    int                           reg_writes = 0;
    int                           stall_cycles = 0;

    pump_cycler_and_heater_thermostat_core dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_temperature      (s_temperature),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_pump_drive       (m_pump_drive),
        .m_heater_drive     (m_heater_drive),
        .m_next_edge_rising (m_next_edge_rising)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic thermostat_tick(input logic [pht_pkg::TEMP_W-1:0] temp);
        int               low_thr;
        int               high_thr;
        logic             restart;
        pht_pkg::result_t r;
        low_thr  = int'(cfg_mirror.set_temperature) - int'(cfg_mirror.hysteresis);
        high_thr = int'(cfg_mirror.set_temperature) + int'(cfg_mirror.hysteresis);
        restart  = 1'b0;
        edge_rising = ~edge_rising;
        if (cfg_mirror.pump_on_ticks == '0) begin
            pump_on = 1'b0;
        end else if (cfg_mirror.pump_on_ticks > pht_pkg::ALWAYS_ON_LIMIT) begin
            pump_on = 1'b1;
        end else begin
            if (tick_count == '0) begin
                pump_on = 1'b1;
            end else if (tick_count == pht_pkg::COUNT_W'(cfg_mirror.pump_on_ticks)) begin
                pump_on = 1'b0;
            end else if (int'(tick_count) > int'(cfg_mirror.pump_on_ticks)
                         + int'(cfg_mirror.pump_off_ticks)) begin
                restart = 1'b1;
            end
            tick_count = restart ? '0 : tick_count + 1'b1;
        end
        if (cfg_mirror.heat_enable) begin
            if (int'(temp) < low_thr) begin
                heater_on = 1'b1;
            end else if (int'(temp) > high_thr) begin
                heater_on = 1'b0;
            end
        end else begin
            heater_on = 1'b0;
        end
        r.pump_drive       = pump_on;
        r.heater_drive     = heater_on;
        r.next_edge_rising = edge_rising;
        expected_drives.push_back(r);
    endtask

    // driver: new beat or idle at the falling edge, hold until taken
    always @(negedge aclk) begin : drive_proc
        logic                       nxt_valid;
        logic [pht_pkg::TEMP_W-1:0] nxt_temp;
        nxt_valid = s_valid;
        nxt_temp  = s_temperature;
        if (!aresetn) begin
            nxt_valid = 1'b0;
        end else if (!s_valid || s_taken) begin
            nxt_valid = 1'b0;
            if (pending_temps.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt_temp  = pending_temps.pop_front();
                nxt_valid = 1'b1;
            end
        end
        s_valid       <= nxt_valid;
        s_temperature <= nxt_temp;
        m_ready       <= aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // monitor, model update and watchdog
    always @(posedge aclk) begin : monitor_proc
        pht_pkg::result_t want;
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            thermostat_tick(s_temperature);
            ticks_sent++;
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_drives.size() == 0) begin
                $display("%0t: result beat with none expected: pump %b heater %b edge %b",
                         $time, m_pump_drive, m_heater_drive, m_next_edge_rising);
                errors++;
            end else begin
                want = expected_drives.pop_front();
                beats_checked++;
                if (m_pump_drive !== want.pump_drive) begin
                    $display("%0t: pump_drive expected %b actual %b",
                             $time, want.pump_drive, m_pump_drive);
                    errors++;
                end
                if (m_heater_drive !== want.heater_drive) begin
                    $display("%0t: heater_drive expected %b actual %b",
                             $time, want.heater_drive, m_heater_drive);
                    errors++;
                end
                if (m_next_edge_rising !== want.next_edge_rising) begin
                    $display("%0t: next_edge_rising expected %b actual %b",
                             $time, want.next_edge_rising, m_next_edge_rising);
                    errors++;
                end
            end
        end
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= 4000) begin
            $display("%0t: no beat moved for %0d cycles", $time, stall_cycles);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [pht_pkg::IDX_W-1:0] idx,
                             input logic [pht_pkg::DATA_W-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = pht_pkg::ADDR_W'({idx, 2'b00});
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            pht_pkg::REG_PUMP_ON:
                cfg_mirror.pump_on_ticks   = value[pht_pkg::TICKS_W-1:0];
            pht_pkg::REG_PUMP_OFF:
                cfg_mirror.pump_off_ticks  = value[pht_pkg::TICKS_W-1:0];
            pht_pkg::REG_HEAT_EN:
                cfg_mirror.heat_enable     = value[0];
            pht_pkg::REG_SET_TEMP:
                cfg_mirror.set_temperature = value[pht_pkg::TEMP_W-1:0];
            pht_pkg::REG_HYST:
                cfg_mirror.hysteresis      = value[pht_pkg::TEMP_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic configure(input int on_t, input int off_t, input int heat,
                             input int set_t, input int hyst);
        write_reg(pht_pkg::REG_PUMP_ON, on_t);
        write_reg(pht_pkg::REG_PUMP_OFF, off_t);
        write_reg(pht_pkg::REG_HEAT_EN, heat);
        write_reg(pht_pkg::REG_SET_TEMP, set_t);
        write_reg(pht_pkg::REG_HYST, hyst);
    endtask

    // wait until every beat is through, then let the pipeline settle
    task automatic drain();
        do begin
            @(negedge aclk);
            #1;
        end while (pending_temps.size() != 0 || s_valid || expected_drives.size() != 0);
        repeat (4) @(negedge aclk);
    endtask

    initial begin : stimulus
        int rnd_sent;
        int burst;
        int sel;
        int on_t;
        int off_t;
        int hyst;
        int span;
        int t;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // reset defaults: pump forced off, heating disabled
        pending_temps = '{16'h0000, 16'hFFFF};
        drain();
        // timed pump, band edges around 1000 +/- 100
        configure(2, 0, 1, 1000, 100);
        pending_temps = '{16'd0, 16'd1000, 16'd1100, 16'd1101, 16'd900, 16'd899, 16'hFFFF};
        drain();
        // longest timed on, lower threshold negative
        configure(3600, 4095, 1, 0, 65535);
        pending_temps = '{16'd0, 16'hFFFF, 16'h8000};
        drain();
        // pump forced on, zero band at the top of range
        configure(4095, 4095, 1, 65535, 0);
        pending_temps = '{16'hFFFE, 16'hFFFF};
        drain();
        configure(3601, 0, 0, 65535, 0);
        pending_temps = '{16'd0};
        drain();
        configure(6, 6, 1, 65535, 65535);
        pending_temps = '{16'd0, 16'hFFFF, 16'd1, 16'h7FFF};
        drain();
        // count now past the shorter period: restart
        configure(1, 1, 1, 200, 10);
        pending_temps = '{16'd100, 16'd300, 16'd205};
        drain();

        rnd_sent = 0;
        while (rnd_sent < 600) begin
            if (rnd_sent < 200) begin
                send_idle_pct = 29;
                recv_idle_pct = 62;
            end else if (rnd_sent < 400) begin
                send_idle_pct = 62;
                recv_idle_pct = 29;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            sel = $urandom_range(9);
            if (sel == 0) begin
                on_t = 0;
            end else if (sel == 1) begin
                on_t = $urandom_range(4095, 3601);
            end else if (sel == 2) begin
                on_t = $urandom_range(3600, 9);
            end else begin
                on_t = $urandom_range(8, 1);
            end
            off_t = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(8);
            hyst  = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(300);
            configure(on_t, off_t, $urandom_range(3) != 0, $urandom_range(65535), hyst);
            burst = $urandom_range(60, 10);
            span  = int'(cfg_mirror.hysteresis) + 20;
            repeat (burst) begin
                if ($urandom_range(3) == 0) begin
                    t = $urandom_range(65535);
                end else begin
                    t = int'(cfg_mirror.set_temperature) + int'($urandom_range(2 * span)) - span;
                    t = (t < 0) ? 0 : (t > 65535) ? 65535 : t;
                end
                pending_temps.push_back(pht_pkg::TEMP_W'(t));
            end
            rnd_sent += burst;
            drain();
        end

        repeat (6) @(negedge aclk);
        $display("Sent %0d ticks over %0d register writes; %0d result beats checked.",
                 ticks_sent, reg_writes, beats_checked);
        $display("Pump modes off, timed and forced on; heater band edges and disable covered.");
        if (errors == 0 && expected_drives.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
